// ===== design/thi_pkg.sv =====
// shared types, constants and control structs for the timestamp history interpolator
// no dependencies

package thi_pkg;

    localparam int FUNC_W         = 2;
    localparam int TIME_W         = 32;
    localparam int POS_W          = 32;
    localparam int DELAY_W        = 20;
    localparam int FRAC_W         = 17;
    localparam int DEF_HIST_DEPTH = 64;

    localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RESET = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;
    localparam logic [FRAC_W-1:0] FRAC_MAX = 17'd78643;

    typedef logic signed [TIME_W-1:0] ts_t;
    typedef logic signed [POS_W-1:0]  pos_t;

    typedef struct packed {
        ts_t  ts;
        pos_t x;
        pos_t y;
        pos_t z;
    } entry_t;

    typedef struct packed {
        logic load;
        logic push_wr;
        logic rst_rd;
        logic rst_wr0;
        logic rst_wr1;
        logic q_rd;
        logic walk;
        logic prep;
        logic div_step;
        logic mul_step;
        logic out_load;
    } thi_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              walk_done;
        logic              need_div;
        logic              div_done;
        logic              mul_done;
    } thi_stat_t;

endpackage

// ===== design/thi_if.sv =====
// valid/ready channel interfaces for input items and result items
// depends on thi_pkg

interface thi_in_if import thi_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    ts_t               sample_time;
    pos_t              pos_x;
    pos_t              pos_y;
    pos_t              pos_z;

    modport source(output valid, func, sample_time, pos_x, pos_y, pos_z, input ready);
    modport sink(input valid, func, sample_time, pos_x, pos_y, pos_z, output ready);
endinterface

interface thi_out_if import thi_pkg::*; ();
    logic valid;
    logic ready;
    pos_t out_x;
    pos_t out_y;
    pos_t out_z;
    logic bracket_found;
    logic held_older;

    modport source(output valid, out_x, out_y, out_z, bracket_found, held_older, input ready);
    modport sink(input valid, out_x, out_y, out_z, bracket_found, held_older, output ready);
endinterface

// ===== design/timestamp_history_interpolator_top.sv =====
// timestamp history interpolator: ring of timestamped positions with delayed lerp query
// depends on thi_pkg, thi_if, thi_ctrl, thi_datapath
//
// in_ch carries one command per beat: push stores a sample at the next ring slot,
// reset clears the ring keeping the head sample in slots 0 and 1, query interpolates
// the position at sample_time minus interp_delay. only a query produces a beat on out_ch.
// cfg_we/cfg_wdata write interp_delay; write only while the block is idle.
// a query passes from acceptance to result valid through the walk, the divider and the
// multiplier: the walk reads one history entry per cycle from the single ram read port,
// the divider is a restoring unit of 17 one-bit steps when a fraction must be computed,
// then one shared multiplier handles x, y, z in turn.
// the result sits in an output register; the next command is accepted while it waits.
// if the receiver stalls, a following query finishes and holds until the register frees.
// reset empties the ring via per-slot valid bits at once, head 0, delay 0, no result pending.

module timestamp_history_interpolator_top import thi_pkg::*; #(
    parameter int HIST_DEPTH = DEF_HIST_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    thi_in_if.sink             in_ch,
    thi_out_if.source          out_ch,
    input  logic               cfg_we,
    input  logic [DELAY_W-1:0] cfg_wdata
);

    thi_cmd_t  cmd;
    thi_stat_t st;

    thi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .st        (st),
        .cmd       (cmd)
    );

    thi_datapath #(.HIST_DEPTH(HIST_DEPTH)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .in_func     (in_ch.func),
        .in_time     (in_ch.sample_time),
        .in_x        (in_ch.pos_x),
        .in_y        (in_ch.pos_y),
        .in_z        (in_ch.pos_z),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_x       (out_ch.out_x),
        .out_y       (out_ch.out_y),
        .out_z       (out_ch.out_z),
        .out_bracket (out_ch.bracket_found),
        .out_held    (out_ch.held_older)
    );

endmodule

// ===== design/thi_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies

module thi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/thi_ctrl.sv =====
// controller state machine: sequences push, ring reset and query through the datapath
// depends on thi_pkg

module thi_ctrl import thi_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  thi_stat_t st,
    output thi_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_PUSH, S_RRD, S_RW0, S_RW1,
        S_QRD, S_WALK, S_PREP, S_DIV, S_MUL, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                unique case (st.func)
                    FUNC_PUSH:  state_next = S_PUSH;
                    FUNC_RESET: state_next = S_RRD;
                    FUNC_QUERY: state_next = S_QRD;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_PUSH:
            begin
                cmd.push_wr = 1'b1;
                state_next  = S_IDLE;
            end
            S_RRD:
            begin
                cmd.rst_rd = 1'b1;
                state_next = S_RW0;
            end
            S_RW0:
            begin
                cmd.rst_wr0 = 1'b1;
                state_next  = S_RW1;
            end
            S_RW1:
            begin
                cmd.rst_wr1 = 1'b1;
                state_next  = S_IDLE;
            end
            S_QRD:
            begin
                cmd.q_rd   = 1'b1;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (st.walk_done)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = st.need_div ? S_DIV : S_MUL;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (st.mul_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result loaded while previous beat still pending");

    a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> (state_reg == S_DEC))
        else $error("accepted beat not decoded");

    a_skip_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PREP && !st.need_div) |=> (state_reg == S_MUL))
        else $error("division entered without need");

    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result valid raised outside output state");

endmodule

// ===== design/thi_datapath.sv =====
// datapath: history ram, valid bits, head pointer, walk registers, divider and lerp
// depends on thi_pkg and thi_ram

module thi_datapath import thi_pkg::*; #(
    parameter int HIST_DEPTH = DEF_HIST_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  thi_cmd_t           cmd,
    output thi_stat_t          st,
    input  logic [FUNC_W-1:0]  in_func,
    input  ts_t                in_time,
    input  pos_t               in_x,
    input  pos_t               in_y,
    input  pos_t               in_z,
    input  logic               cfg_we,
    input  logic [DELAY_W-1:0] cfg_wdata,
    output pos_t               out_x,
    output pos_t               out_y,
    output pos_t               out_z,
    output logic               out_bracket,
    output logic               out_held
);

    localparam int IW     = $clog2(HIST_DEPTH);
    localparam int TGT_W  = TIME_W + 2;
    localparam int NUM_W  = TIME_W + 3;
    localparam int REM_W  = NUM_W + 1;
    localparam int DIF_W  = POS_W + 1;
    localparam int PROD_W = FRAC_W + 1 + DIF_W;
    localparam int SUM_W  = PROD_W - 16 + 1;
    localparam logic [IW:0]   DEPTH_W = (IW+1)'(HIST_DEPTH);
    localparam logic [IW-1:0] LAST_I  = IW'(HIST_DEPTH - 2);
    localparam logic [IW-1:0] TOP_I   = IW'(HIST_DEPTH - 1);
    localparam logic [IW-1:0] ONE_I   = IW'(1);

    logic [FUNC_W-1:0]        func_reg;
    entry_t                   in_reg;
    logic signed [TGT_W-1:0]  target_reg;
    logic [DELAY_W-1:0]       delay_reg;
    logic [IW-1:0]            head_reg;
    logic [HIST_DEPTH-1:0]    valid_reg;
    logic                     vrd_reg;
    logic [IW-1:0]            i_reg;
    logic                     walk_en_reg;
    entry_t                   hd_reg, h1_reg, pv_reg, n_reg, o_reg;
    logic                     bracket_reg, held_reg;
    logic [REM_W-1:0]         rem_reg, ad_reg;
    logic [FRAC_W-1:0]        q_reg, frac_reg;
    logic [4:0]               dcnt_reg;
    logic [1:0]               m_reg;
    logic signed [PROD_W-1:0] prod_reg;
    pos_t                     res_reg [3];

    logic                     we;
    logic [IW-1:0]            waddr, raddr, rd_off, push_addr;
    logic [IW:0]              wrap_tmp;
    entry_t                   wdata, cur;
    logic [$bits(entry_t)-1:0] rdata;
    logic signed [TGT_W-1:0]  cur_ext;
    logic                     cur_ge, cur_zero, stop, brk;
    logic signed [NUM_W-1:0]  n_ext, o_ext, tgt_ext, num, den;
    logic [NUM_W-1:0]         an, ad;
    logic                     p_held, p_eq, p_neg, p_sat;
    logic [REM_W-1:0]         trial;
    logic                     qbit;
    logic [FRAC_W-1:0]        q_next;
    pos_t                     n_lane, o_lane, o_prev;
    logic signed [DIF_W-1:0]  dsel;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  sum;
    pos_t                     sat_res;

    function automatic pos_t lane(entry_t e, logic [1:0] idx);
        pos_t r;
        case (idx)
            2'd0:    r = e.x;
            2'd1:    r = e.y;
            default: r = e.z;
        endcase
        return r;
    endfunction

    thi_ram #(.WIDTH($bits(entry_t)), .DEPTH(HIST_DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign cur = vrd_reg ? entry_t'(rdata) : '0;

    always_comb
    begin
        rd_off   = (cmd.q_rd || cmd.rst_rd || cmd.rst_wr0) ? '0 : i_reg + ONE_I;
        wrap_tmp = {1'b0, head_reg} + DEPTH_W - {1'b0, rd_off};
        if (wrap_tmp >= DEPTH_W)
        begin
            wrap_tmp = wrap_tmp - DEPTH_W;
        end
        raddr     = wrap_tmp[IW-1:0];
        push_addr = (head_reg == TOP_I) ? '0 : head_reg + ONE_I;
    end

    always_comb
    begin
        we    = cmd.push_wr || cmd.rst_wr0 || cmd.rst_wr1;
        waddr = '0;
        wdata = cur;
        if (cmd.push_wr)
        begin
            waddr = push_addr;
            wdata = in_reg;
        end
        else if (cmd.rst_wr1)
        begin
            waddr = ONE_I;
        end
    end

    // walk compare
    always_comb
    begin
        cur_ext  = {{(TGT_W-TIME_W){cur.ts[TIME_W-1]}}, cur.ts};
        cur_ge   = cur_ext >= target_reg;
        cur_zero = (cur.ts == '0);
        brk      = walk_en_reg && !cur_zero && !cur_ge;
        stop     = (i_reg != '0) && ((!walk_en_reg && i_reg == ONE_I) || cur_zero
                   || !cur_ge || i_reg == LAST_I);
    end

    // fraction setup
    always_comb
    begin
        n_ext   = {{(NUM_W-TIME_W){n_reg.ts[TIME_W-1]}}, n_reg.ts};
        o_ext   = {{(NUM_W-TIME_W){o_reg.ts[TIME_W-1]}}, o_reg.ts};
        tgt_ext = {target_reg[TGT_W-1], target_reg};
        num     = tgt_ext - o_ext;
        den     = n_ext - o_ext;
        an      = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        ad      = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
        p_held  = (n_reg.ts == '0);
        p_eq    = (n_reg.ts == o_reg.ts);
        p_neg   = num[NUM_W-1] ^ den[NUM_W-1];
        p_sat   = {1'b0, an} >= {ad, 1'b0};
    end

    always_comb
    begin
        trial  = rem_reg - ad_reg;
        qbit   = !trial[REM_W-1];
        q_next = {q_reg[FRAC_W-2:0], qbit};
    end

    // lerp lane: multiply stage then add and saturate stage
    always_comb
    begin
        n_lane = lane(n_reg, m_reg);
        o_lane = lane(o_reg, m_reg);
        o_prev = lane(o_reg, 2'(m_reg - 2'd1));
        dsel   = {n_lane[POS_W-1], n_lane} - {o_lane[POS_W-1], o_lane};
        prod   = $signed({1'b0, frac_reg}) * dsel;
        sum    = $signed({prod_reg[PROD_W-1], prod_reg[PROD_W-1:16]})
                 + $signed({{(SUM_W-POS_W){o_prev[POS_W-1]}}, o_prev});
        if (sum[SUM_W-1:POS_W-1] == '0 || sum[SUM_W-1:POS_W-1] == '1)
        begin
            sat_res = sum[POS_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            sat_res = {1'b1, {(POS_W-1){1'b0}}};
        end
        else
        begin
            sat_res = {1'b0, {(POS_W-1){1'b1}}};
        end
    end

    always_comb
    begin
        st.func      = func_reg;
        st.walk_done = stop;
        st.need_div  = !p_held && !p_eq && !p_neg && !p_sat;
        st.div_done  = (dcnt_reg == 5'd16);
        st.mul_done  = (m_reg == 2'd3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= '0;
            head_reg  <= '0;
            valid_reg <= '0;
            func_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                delay_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                func_reg <= in_func;
            end
            if (cmd.push_wr)
            begin
                head_reg             <= push_addr;
                valid_reg[push_addr] <= 1'b1;
            end
            if (cmd.rst_wr0)
            begin
                valid_reg    <= '0;
                valid_reg[0] <= 1'b1;
            end
            if (cmd.rst_wr1)
            begin
                valid_reg[1] <= 1'b1;
                head_reg     <= ONE_I;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        vrd_reg <= valid_reg[raddr];
        if (cmd.load)
        begin
            in_reg     <= '{ts: in_time, x: in_x, y: in_y, z: in_z};
            target_reg <= {{(TGT_W-TIME_W){in_time[TIME_W-1]}}, in_time}
                          - $signed({{(TGT_W-DELAY_W){1'b0}}, delay_reg});
        end
        if (cmd.q_rd)
        begin
            i_reg <= '0;
        end
        if (cmd.walk)
        begin
            i_reg <= i_reg + ONE_I;
            if (i_reg == '0)
            begin
                hd_reg      <= cur;
                pv_reg      <= cur;
                walk_en_reg <= cur_ge;
            end
            else
            begin
                if (i_reg == ONE_I)
                begin
                    h1_reg <= cur;
                end
                if (stop)
                begin
                    bracket_reg <= brk;
                    n_reg       <= brk ? pv_reg : hd_reg;
                    o_reg       <= (brk || i_reg == ONE_I) ? cur : h1_reg;
                end
                else
                begin
                    pv_reg <= cur;
                end
            end
        end
        if (cmd.prep)
        begin
            held_reg <= p_held;
            rem_reg  <= {1'b0, an};
            ad_reg   <= {1'b0, ad};
            q_reg    <= '0;
            dcnt_reg <= '0;
            m_reg    <= '0;
            if (p_eq)
            begin
                frac_reg <= FRAC_ONE;
            end
            else if (p_neg)
            begin
                frac_reg <= '0;
            end
            else if (p_sat)
            begin
                frac_reg <= FRAC_MAX;
            end
        end
        if (cmd.div_step)
        begin
            rem_reg  <= (qbit ? trial : rem_reg) << 1;
            q_reg    <= q_next;
            dcnt_reg <= dcnt_reg + 5'd1;
            if (dcnt_reg == 5'd16)
            begin
                frac_reg <= (q_next > FRAC_MAX) ? FRAC_MAX : q_next;
            end
        end
        if (cmd.mul_step)
        begin
            m_reg <= m_reg + 2'd1;
            if (m_reg != 2'd3)
            begin
                prod_reg <= prod;
            end
            if (m_reg != 2'd0)
            begin
                res_reg[2'(m_reg - 2'd1)] <= held_reg ? o_prev : sat_res;
            end
        end
        if (cmd.out_load)
        begin
            out_x       <= res_reg[0];
            out_y       <= res_reg[1];
            out_z       <= res_reg[2];
            out_bracket <= bracket_reg;
            out_held    <= held_reg;
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for the timestamp history interpolator
// depends on thi_pkg, thi_if and timestamp_history_interpolator_top

module tb_top import thi_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEF_HIST_DEPTH;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        pos_t x;
        pos_t y;
        pos_t z;
        logic bracket;
        logic held;
    } lerp_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [DELAY_W-1:0] cfg_wdata = '0;

    thi_in_if in_ch();
    thi_out_if out_ch();

    timestamp_history_interpolator_top #(.HIST_DEPTH(DEPTH)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #1 clk = ~clk;

    ts_t ring_time [DEPTH];
    pos_t ring_pos [DEPTH][3];
    int unsigned ring_head;
    logic [DELAY_W-1:0] delay_reg;
    lerp_res_t expected_q [$];
    int mismatches = 0;
    int cycles = 0;
    int hold_off = 0;
    int rx_wait = 0;
    bit random_stall = 1'b1;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_PUSH;
        in_ch.sample_time = '0;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.pos_z = '0;
        out_ch.ready = 1'b0;
    end

    function automatic int unsigned back(int unsigned base, int unsigned i);
        return (base + DEPTH - (i % DEPTH)) % DEPTH;
    endfunction

    function automatic pos_t sat(longint v);
        if (v > 64'sd2147483647)
            return 32'h7fffffff;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return pos_t'(v);
    endfunction

    function automatic void clear_ring();
        for (int k = 0; k < DEPTH; k++)
        begin
            ring_time[k] = '0;
            for (int j = 0; j < 3; j++)
                ring_pos[k][j] = '0;
        end
    endfunction

    function automatic void predict_cmd(logic [1:0] fn, ts_t st, pos_t px, pos_t py, pos_t pz);
        longint target, t0, t1, num, den, frac, d, prod, fl;
        longint unsigned an, ad, q;
        int unsigned i0, i1, k;
        ts_t kt;
        pos_t kp [3];
        lerp_res_t r;
        if (fn == FUNC_PUSH)
        begin
            ring_head = (ring_head + 1) % DEPTH;
            ring_time[ring_head] = st;
            ring_pos[ring_head][0] = px;
            ring_pos[ring_head][1] = py;
            ring_pos[ring_head][2] = pz;
        end
        else if (fn == FUNC_RESET)
        begin
            kt = ring_time[ring_head];
            for (int j = 0; j < 3; j++)
                kp[j] = ring_pos[ring_head][j];
            clear_ring();
            for (int s = 0; s < 2; s++)
            begin
                ring_time[s] = kt;
                for (int j = 0; j < 3; j++)
                    ring_pos[s][j] = kp[j];
            end
            ring_head = 1;
        end
        else if (fn == FUNC_QUERY)
        begin
            target = longint'(st) - longint'(delay_reg);
            i0 = ring_head;
            i1 = back(ring_head, 1);
            r.bracket = 1'b0;
            r.held = 1'b0;
            frac = 65536;
            if (longint'(ring_time[i0]) >= target)
            begin
                for (int unsigned i = 1; i < DEPTH - 1; i++)
                begin
                    k = back(ring_head, i);
                    if (ring_time[k] == 0)
                        break;
                    if (longint'(ring_time[k]) < target)
                    begin
                        i0 = back(ring_head, i - 1);
                        i1 = k;
                        r.bracket = 1'b1;
                        break;
                    end
                end
            end
            if (ring_time[i0] == 0)
            begin
                r.held = 1'b1;
                r.x = ring_pos[i1][0];
                r.y = ring_pos[i1][1];
                r.z = ring_pos[i1][2];
            end
            else
            begin
                t0 = ring_time[i0];
                t1 = ring_time[i1];
                if (t0 != t1)
                begin
                    num = target - t1;
                    den = t0 - t1;
                    an = num < 0 ? -num : num;
                    ad = den < 0 ? -den : den;
                    q = (an << 16) / ad;
                    if (((num < 0) != (den < 0)) || q == 0)
                        frac = 0;
                    else
                        frac = q > 78643 ? 78643 : longint'(q);
                end
                for (int j = 0; j < 3; j++)
                begin
                    d = longint'(ring_pos[i0][j]) - longint'(ring_pos[i1][j]);
                    prod = frac * d;
                    fl = prod >= 0 ? (prod >>> 16) : -((-prod + 65535) >>> 16);
                    kp[j] = sat(longint'(ring_pos[i1][j]) + fl);
                end
                r.x = kp[0];
                r.y = kp[1];
                r.z = kp[2];
            end
            expected_q.push_back(r);
        end
    endfunction

    task automatic send_cmd(logic [1:0] fn, ts_t st, pos_t px, pos_t py, pos_t pz);
        int gap;
        gap = random_stall ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func <= fn;
        in_ch.sample_time <= st;
        in_ch.pos_x <= px;
        in_ch.pos_y <= py;
        in_ch.pos_z <= pz;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_cmd(fn, st, px, py, pz);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic set_delay(logic [DELAY_W-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        delay_reg = v;
    endtask

    function automatic pos_t rand_pos();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return pos_t'($urandom_range(0, 2000)) - 1000;
            default: return pos_t'($urandom);
        endcase
    endfunction

    task automatic push_rand(ts_t t);
        send_cmd(FUNC_PUSH, t, rand_pos(), rand_pos(), rand_pos());
    endtask

    task automatic test_directed();
        send_cmd(FUNC_QUERY, 32'sd100, '0, '0, '0);
        send_cmd(FUNC_PUSH, 32'sd10, 32'sh00010000, -32'sh00010000, 32'sh7fffffff);
        send_cmd(FUNC_PUSH, 32'sd20, 32'sh00030000, 32'sh7fffffff, 32'sh80000000);
        send_cmd(FUNC_QUERY, 32'sd15, '0, '0, '0);
        send_cmd(FUNC_QUERY, 32'sd5, '0, '0, '0);
        send_cmd(FUNC_QUERY, 32'sd40, '0, '0, '0);
        send_cmd(FUNC_PUSH, 32'sd20, 32'sh7fffffff, 32'sh80000000, 32'sh0);
        send_cmd(FUNC_QUERY, 32'sd20, '0, '0, '0);
        send_cmd(FUNC_PUSH, '0, 32'sh11110000, 32'sh2, 32'sh3);
        send_cmd(FUNC_QUERY, 32'sd18, '0, '0, '0);
        send_cmd(2'd3, 32'sd18, '0, '0, '0);
        send_cmd(FUNC_PUSH, 32'h7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh5);
        send_cmd(FUNC_PUSH, 32'h80000000, 32'sh7fffffff, 32'sh80000000, -32'sh5);
        send_cmd(FUNC_QUERY, 32'h7fffffff, '0, '0, '0);
        send_cmd(FUNC_QUERY, 32'h80000000, '0, '0, '0);
        send_cmd(FUNC_RESET, '0, '0, '0, '0);
        send_cmd(FUNC_QUERY, 32'h80000000, '0, '0, '0);
        send_cmd(FUNC_PUSH, 32'sd50, 32'sh1000, 32'sh2000, 32'sh3000);
        send_cmd(FUNC_QUERY, 32'sd45, '0, '0, '0);
        send_cmd(FUNC_QUERY, 32'sd60, '0, '0, '0);
    endtask

    task automatic test_full_ring(logic [DELAY_W-1:0] dly);
        ts_t t;
        set_delay(dly);
        t = ts_t'($urandom_range(1, 1000));
        for (int n = 0; n < DEPTH + 4; n++)
        begin
            t = t + ts_t'($urandom_range(1, 300));
            push_rand(t);
        end
        send_cmd(FUNC_QUERY, t + ts_t'($urandom_range(0, 400)), '0, '0, '0);
        send_cmd(FUNC_QUERY, t - ts_t'($urandom_range(0, 20000)), '0, '0, '0);
    endtask

    task automatic test_random(int count);
        ts_t t;
        int kind;
        t = ts_t'($urandom);
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 50)
            begin
                t = ($urandom_range(0, 19) == 0) ? ts_t'($urandom) : t + ts_t'($urandom_range(0, 500));
                push_rand(($urandom_range(0, 39) == 0) ? ts_t'(0) : t);
            end
            else if (kind < 90)
                send_cmd(FUNC_QUERY, t + ts_t'($urandom_range(0, 600))
                    - ts_t'($urandom_range(0, 3000)), rand_pos(), rand_pos(), rand_pos());
            else if (kind < 95)
                send_cmd(FUNC_RESET, ts_t'($urandom), rand_pos(), '0, '0);
            else if (kind < 98)
                send_cmd(FUNC_QUERY, ts_t'($urandom), '0, '0, '0);
            else
                send_cmd(2'd3, ts_t'($urandom), '0, '0, '0);
        end
    endtask

    task automatic test_backpressure();
        drain();
        hold_off = 300;
        random_stall = 1'b0;
        for (int n = 0; n < 12; n++)
            send_cmd(FUNC_QUERY, ts_t'($urandom), '0, '0, '0);
        random_stall = 1'b1;
    endtask

    // receiver may drop ready at random after each accepted beat
    always @(posedge clk)
    begin
        int draw;
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ch.ready <= 1'b0;
        end
        else if (!random_stall)
            out_ch.ready <= 1'b1;
        else if (out_ch.valid && out_ch.ready)
        begin
            draw = $urandom_range(0, 4);
            rx_wait <= draw;
            out_ch.ready <= (draw == 0);
        end
        else if (rx_wait > 0)
        begin
            rx_wait <= rx_wait - 1;
            out_ch.ready <= (rx_wait == 1);
        end
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        lerp_res_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat x=%h", out_ch.out_x);
            end
            else
            begin
                e = expected_q.pop_front();
                if (e.x !== out_ch.out_x || e.y !== out_ch.out_y || e.z !== out_ch.out_z ||
                    e.bracket !== out_ch.bracket_found || e.held !== out_ch.held_older)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %h %h %h b%b h%b got %h %h %h b%b h%b",
                            e.x, e.y, e.z, e.bracket, e.held, out_ch.out_x, out_ch.out_y,
                            out_ch.out_z, out_ch.bracket_found, out_ch.held_older);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        clear_ring();
        ring_head = 0;
        delay_reg = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        set_delay(20'd3);
        test_directed();
        test_full_ring(20'd100);
        test_full_ring(20'hfffff);
        test_backpressure();
        set_delay(20'd0);
        test_random(200);
        set_delay(20'd250);
        test_random(200);
        set_delay(20'hfffff);
        test_random(80);
        set_delay(20'd1000);
        test_random(200);
        drain();
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
